// ===== rtl/jmsp_pkg.sv =====
// Shared types, codes and constants of the JPEG marker segment parser.
`default_nettype none

package jmsp_pkg;

   localparam int OFFSET_BITS = 24;

   localparam logic [15:0] M_SOI   = 16'hFFD8;
   localparam logic [15:0] M_EOI   = 16'hFFD9;
   localparam logic [15:0] M_DQT   = 16'hFFDB;
   localparam logic [15:0] M_DHT   = 16'hFFC4;
   localparam logic [15:0] M_DRI   = 16'hFFDD;
   localparam logic [15:0] M_COM   = 16'hFFFE;
   localparam logic [15:0] M_DAC   = 16'hFFCC;
   localparam logic [15:0] M_APP0  = 16'hFFE0;
   localparam logic [15:0] M_APP15 = 16'hFFEF;

   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_D9 = 8'hD9;

   localparam logic [4:0] KIND_NO_SOI   = 5'd0;
   localparam logic [4:0] KIND_BAD_LEN  = 5'd1;
   localparam logic [4:0] KIND_MARKER   = 5'd2;
   localparam logic [4:0] KIND_LENGTH   = 5'd3;
   localparam logic [4:0] KIND_DQT_PT   = 5'd4;
   localparam logic [4:0] KIND_DQT_ENT  = 5'd5;
   localparam logic [4:0] KIND_SKIPPED  = 5'd6;
   localparam logic [4:0] KIND_DRI_RI   = 5'd7;
   localparam logic [4:0] KIND_SOF_P    = 5'd8;
   localparam logic [4:0] KIND_SOF_Y    = 5'd9;
   localparam logic [4:0] KIND_SOF_X    = 5'd10;
   localparam logic [4:0] KIND_SOF_NF   = 5'd11;
   localparam logic [4:0] KIND_SOF_C    = 5'd12;
   localparam logic [4:0] KIND_SOF_HV   = 5'd13;
   localparam logic [4:0] KIND_SOF_TQ   = 5'd14;
   localparam logic [4:0] KIND_SOS_NS   = 5'd15;
   localparam logic [4:0] KIND_SOS_CS   = 5'd16;
   localparam logic [4:0] KIND_SOS_TDTA = 5'd17;
   localparam logic [4:0] KIND_SOS_SS   = 5'd18;
   localparam logic [4:0] KIND_SOS_SE   = 5'd19;
   localparam logic [4:0] KIND_SOS_AHAL = 5'd20;

   typedef enum logic [4:0] {
      PH_SOI, PH_HALT, PH_TMARK, PH_DQT_LEN, PH_DQT_PT, PH_DQT_ENT,
      PH_SKIP_LEN, PH_SKIP, PH_DRI_LEN, PH_DRI_RI,
      PH_SOF_LEN, PH_SOF_P, PH_SOF_Y, PH_SOF_X, PH_SOF_NF,
      PH_SOF_C, PH_SOF_HV, PH_SOF_TQ,
      PH_SOS_LEN, PH_SOS_NS, PH_SOS_CS, PH_SOS_TDTA,
      PH_SOS_SS, PH_SOS_SE, PH_SOS_AHAL, PH_ENTROPY
   } jmsp_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_stream;
   } jmsp_word_type;

   typedef struct packed {
      logic        hit;
      logic [4:0]  field_kind;
      logic [15:0] field_value;
      logic [23:0] field_offset;
      logic [7:0]  field_index;
   } jmsp_result_type;

endpackage

`default_nettype wire

// ===== rtl/jmsp_if.sv =====
// Valid/ready channel interfaces for the input bytes and the parsed field words.
`default_nettype none

interface jmsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_stream;

   modport source (output valid, output data_byte, output new_stream, input ready);
   modport sink   (input valid, input data_byte, input new_stream, output ready);
endinterface

interface jmsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  field_kind;
   logic [15:0] field_value;
   logic [23:0] field_offset;
   logic [7:0]  field_index;

   modport source (output valid, output field_kind, output field_value,
                   output field_offset, output field_index, input ready);
   modport sink   (input valid, input field_kind, input field_value,
                   input field_offset, input field_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/jmsp_core.sv =====
// Parser state registers and the per-byte parse step.
`default_nettype none

module jmsp_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire jmsp_pkg::jmsp_word_type  word,
   output jmsp_pkg::jmsp_result_type     result
);

   localparam int OB = jmsp_pkg::OFFSET_BITS;

   jmsp_pkg::jmsp_phase_type phase_ff, phase_in, cur_phase;
   logic          byte_cnt_ff, byte_cnt_in, cur_byte_cnt;
   logic [7:0]    high_byte_ff, high_byte_in;
   logic [OB-1:0] byte_offset_ff, byte_offset_in, cur_offset;
   logic [OB-1:0] field_start_ff, field_start_in, cur_field_start;
   logic [OB-1:0] seg_end_ff, seg_end_in, cur_seg_end;
   logic          precision_ff, precision_in, cur_precision;
   logic [5:0]    entry_index_ff, entry_index_in, cur_entry_index;
   logic [7:0]    frame_comp_ff, frame_comp_in, cur_frame_comp;
   logic [7:0]    scan_comp_ff, scan_comp_in, cur_scan_comp;
   logic [7:0]    comp_index_ff, comp_index_in, cur_comp_index;
   logic          after_ff_ff, after_ff_in, cur_after_ff;
   logic          scan_tables_ff, scan_tables_in, cur_scan_tables;

   logic [7:0]    b;
   logic          wide;
   logic [15:0]   v;
   logic [OB-1:0] start;
   logic [OB-1:0] next_offset;
   logic [OB-1:0] seg_left;
   logic [OB-1:0] dqt_size;
   logic [7:0]    comp_next;

   // a new_stream word sees the reset state
   always_comb begin
      if (word.new_stream) begin
         cur_phase       = jmsp_pkg::PH_SOI;
         cur_byte_cnt    = 1'b0;
         cur_offset      = '0;
         cur_field_start = '0;
         cur_seg_end     = '0;
         cur_precision   = 1'b0;
         cur_entry_index = '0;
         cur_frame_comp  = '0;
         cur_scan_comp   = '0;
         cur_comp_index  = '0;
         cur_after_ff    = 1'b0;
         cur_scan_tables = 1'b0;
      end else begin
         cur_phase       = phase_ff;
         cur_byte_cnt    = byte_cnt_ff;
         cur_offset      = byte_offset_ff;
         cur_field_start = field_start_ff;
         cur_seg_end     = seg_end_ff;
         cur_precision   = precision_ff;
         cur_entry_index = entry_index_ff;
         cur_frame_comp  = frame_comp_ff;
         cur_scan_comp   = scan_comp_ff;
         cur_comp_index  = comp_index_ff;
         cur_after_ff    = after_ff_ff;
         cur_scan_tables = scan_tables_ff;
      end
   end

   always_comb begin
      b           = word.data_byte;
      next_offset = cur_offset + OB'(1);
      seg_left    = cur_seg_end - cur_offset;
      comp_next   = cur_comp_index + 8'd1;
      dqt_size    = (b[7:4] != 4'd0) ? OB'(129) : OB'(65);

      case (cur_phase)
         jmsp_pkg::PH_SOI, jmsp_pkg::PH_TMARK, jmsp_pkg::PH_DQT_LEN,
         jmsp_pkg::PH_SKIP_LEN, jmsp_pkg::PH_DRI_LEN, jmsp_pkg::PH_DRI_RI,
         jmsp_pkg::PH_SOF_LEN, jmsp_pkg::PH_SOF_Y, jmsp_pkg::PH_SOF_X,
         jmsp_pkg::PH_SOS_LEN: wide = 1'b1;
         jmsp_pkg::PH_DQT_ENT: wide = cur_precision;
         default:              wide = 1'b0;
      endcase

      if (wide) begin
         v     = {high_byte_ff, b};
         start = cur_field_start;
      end else begin
         v     = {8'd0, b};
         start = cur_offset;
      end

      phase_in       = cur_phase;
      byte_cnt_in    = cur_byte_cnt;
      high_byte_in   = high_byte_ff;
      byte_offset_in = next_offset;
      field_start_in = cur_field_start;
      seg_end_in     = cur_seg_end;
      precision_in   = cur_precision;
      entry_index_in = cur_entry_index;
      frame_comp_in  = cur_frame_comp;
      scan_comp_in   = cur_scan_comp;
      comp_index_in  = cur_comp_index;
      after_ff_in    = cur_after_ff;
      scan_tables_in = cur_scan_tables;

      result              = '0;
      result.field_value  = v;
      result.field_offset = 24'(start);

      if (cur_phase == jmsp_pkg::PH_HALT) begin
         result.hit = 1'b0;
      end else if (cur_phase == jmsp_pkg::PH_ENTROPY) begin
         if (cur_after_ff && b == jmsp_pkg::BYTE_D9) begin
            phase_in            = jmsp_pkg::PH_HALT;
            after_ff_in         = 1'b0;
            result.hit          = 1'b1;
            result.field_kind   = jmsp_pkg::KIND_MARKER;
            result.field_value  = jmsp_pkg::M_EOI;
            result.field_offset = 24'(cur_field_start);
         end else if (b == jmsp_pkg::BYTE_FF) begin
            after_ff_in    = 1'b1;
            field_start_in = cur_offset;
         end else begin
            after_ff_in = 1'b0;
         end
      end else if (cur_phase == jmsp_pkg::PH_SKIP) begin
         if (!cur_byte_cnt) begin
            result.hit          = 1'b1;
            result.field_kind   = jmsp_pkg::KIND_SKIPPED;
            result.field_value  = 16'(seg_left);
            result.field_offset = 24'(cur_offset);
            byte_cnt_in         = 1'b1;
         end
         if (next_offset == cur_seg_end) begin
            phase_in    = jmsp_pkg::PH_TMARK;
            byte_cnt_in = 1'b0;
         end
      end else if (wide && !cur_byte_cnt) begin
         high_byte_in   = b;
         field_start_in = cur_offset;
         byte_cnt_in    = 1'b1;
      end else begin
         byte_cnt_in = 1'b0;
         result.hit  = 1'b1;
         unique case (cur_phase)
            jmsp_pkg::PH_SOI: begin
               if (v == jmsp_pkg::M_SOI) begin
                  phase_in          = jmsp_pkg::PH_TMARK;
                  result.field_kind = jmsp_pkg::KIND_MARKER;
               end else begin
                  phase_in          = jmsp_pkg::PH_HALT;
                  result.field_kind = jmsp_pkg::KIND_NO_SOI;
               end
            end
            jmsp_pkg::PH_TMARK: begin
               result.field_kind = jmsp_pkg::KIND_MARKER;
               if (v == jmsp_pkg::M_DQT) begin
                  phase_in = jmsp_pkg::PH_DQT_LEN;
               end else if (v == jmsp_pkg::M_DHT || v == jmsp_pkg::M_COM ||
                            v == jmsp_pkg::M_DAC ||
                            (v >= jmsp_pkg::M_APP0 && v <= jmsp_pkg::M_APP15)) begin
                  phase_in = jmsp_pkg::PH_SKIP_LEN;
               end else if (v == jmsp_pkg::M_DRI) begin
                  phase_in = jmsp_pkg::PH_DRI_LEN;
               end else if (cur_scan_tables) begin
                  phase_in = jmsp_pkg::PH_SOS_LEN;
               end else begin
                  phase_in = jmsp_pkg::PH_SOF_LEN;
               end
            end
            jmsp_pkg::PH_DQT_LEN, jmsp_pkg::PH_SKIP_LEN: begin
               if (v < 16'd2) begin
                  phase_in          = jmsp_pkg::PH_TMARK;
                  result.field_kind = jmsp_pkg::KIND_BAD_LEN;
               end else begin
                  seg_end_in        = start + OB'(v);
                  result.field_kind = jmsp_pkg::KIND_LENGTH;
                  if (v == 16'd2) begin
                     phase_in = jmsp_pkg::PH_TMARK;
                  end else if (cur_phase == jmsp_pkg::PH_DQT_LEN) begin
                     phase_in = jmsp_pkg::PH_DQT_PT;
                  end else begin
                     phase_in = jmsp_pkg::PH_SKIP;
                  end
               end
            end
            jmsp_pkg::PH_DQT_PT: begin
               precision_in   = (b[7:4] != 4'd0);
               if (seg_left < dqt_size) begin
                  seg_end_in = cur_offset + dqt_size;
               end
               entry_index_in    = '0;
               phase_in          = jmsp_pkg::PH_DQT_ENT;
               result.field_kind = jmsp_pkg::KIND_DQT_PT;
            end
            jmsp_pkg::PH_DQT_ENT: begin
               result.field_kind  = jmsp_pkg::KIND_DQT_ENT;
               result.field_index = {2'd0, cur_entry_index};
               entry_index_in     = cur_entry_index + 6'd1;
               if (cur_entry_index == 6'd63) begin
                  phase_in = (next_offset == cur_seg_end) ? jmsp_pkg::PH_TMARK
                                                          : jmsp_pkg::PH_DQT_PT;
               end
            end
            jmsp_pkg::PH_DRI_LEN: begin
               phase_in          = jmsp_pkg::PH_DRI_RI;
               result.field_kind = jmsp_pkg::KIND_LENGTH;
            end
            jmsp_pkg::PH_DRI_RI: begin
               phase_in          = jmsp_pkg::PH_TMARK;
               result.field_kind = jmsp_pkg::KIND_DRI_RI;
            end
            jmsp_pkg::PH_SOF_LEN: begin
               phase_in          = jmsp_pkg::PH_SOF_P;
               result.field_kind = jmsp_pkg::KIND_LENGTH;
            end
            jmsp_pkg::PH_SOF_P: begin
               phase_in          = jmsp_pkg::PH_SOF_Y;
               result.field_kind = jmsp_pkg::KIND_SOF_P;
            end
            jmsp_pkg::PH_SOF_Y: begin
               phase_in          = jmsp_pkg::PH_SOF_X;
               result.field_kind = jmsp_pkg::KIND_SOF_Y;
            end
            jmsp_pkg::PH_SOF_X: begin
               phase_in          = jmsp_pkg::PH_SOF_NF;
               result.field_kind = jmsp_pkg::KIND_SOF_X;
            end
            jmsp_pkg::PH_SOF_NF: begin
               frame_comp_in     = b;
               comp_index_in     = '0;
               result.field_kind = jmsp_pkg::KIND_SOF_NF;
               if (b == 8'd0) begin
                  scan_tables_in = 1'b1;
                  phase_in       = jmsp_pkg::PH_TMARK;
               end else begin
                  phase_in = jmsp_pkg::PH_SOF_C;
               end
            end
            jmsp_pkg::PH_SOF_C: begin
               phase_in           = jmsp_pkg::PH_SOF_HV;
               result.field_kind  = jmsp_pkg::KIND_SOF_C;
               result.field_index = comp_next;
            end
            jmsp_pkg::PH_SOF_HV: begin
               phase_in           = jmsp_pkg::PH_SOF_TQ;
               result.field_kind  = jmsp_pkg::KIND_SOF_HV;
               result.field_index = comp_next;
            end
            jmsp_pkg::PH_SOF_TQ: begin
               comp_index_in      = comp_next;
               result.field_kind  = jmsp_pkg::KIND_SOF_TQ;
               result.field_index = comp_next;
               if (comp_next == cur_frame_comp) begin
                  scan_tables_in = 1'b1;
                  phase_in       = jmsp_pkg::PH_TMARK;
               end else begin
                  phase_in = jmsp_pkg::PH_SOF_C;
               end
            end
            jmsp_pkg::PH_SOS_LEN: begin
               phase_in          = jmsp_pkg::PH_SOS_NS;
               result.field_kind = jmsp_pkg::KIND_LENGTH;
            end
            jmsp_pkg::PH_SOS_NS: begin
               scan_comp_in      = b;
               comp_index_in     = '0;
               phase_in          = (b == 8'd0) ? jmsp_pkg::PH_SOS_SS : jmsp_pkg::PH_SOS_CS;
               result.field_kind = jmsp_pkg::KIND_SOS_NS;
            end
            jmsp_pkg::PH_SOS_CS: begin
               phase_in           = jmsp_pkg::PH_SOS_TDTA;
               result.field_kind  = jmsp_pkg::KIND_SOS_CS;
               result.field_index = comp_next;
            end
            jmsp_pkg::PH_SOS_TDTA: begin
               comp_index_in      = comp_next;
               result.field_kind  = jmsp_pkg::KIND_SOS_TDTA;
               result.field_index = comp_next;
               phase_in           = (comp_next == cur_scan_comp) ? jmsp_pkg::PH_SOS_SS
                                                                 : jmsp_pkg::PH_SOS_CS;
            end
            jmsp_pkg::PH_SOS_SS: begin
               phase_in          = jmsp_pkg::PH_SOS_SE;
               result.field_kind = jmsp_pkg::KIND_SOS_SS;
            end
            jmsp_pkg::PH_SOS_SE: begin
               phase_in          = jmsp_pkg::PH_SOS_AHAL;
               result.field_kind = jmsp_pkg::KIND_SOS_SE;
            end
            jmsp_pkg::PH_SOS_AHAL: begin
               phase_in          = jmsp_pkg::PH_ENTROPY;
               after_ff_in       = 1'b0;
               result.field_kind = jmsp_pkg::KIND_SOS_AHAL;
            end
            default: begin
               phase_in   = jmsp_pkg::PH_HALT;
               result.hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= jmsp_pkg::PH_SOI;
         byte_cnt_ff    <= 1'b0;
         high_byte_ff   <= '0;
         byte_offset_ff <= '0;
         field_start_ff <= '0;
         seg_end_ff     <= '0;
         precision_ff   <= 1'b0;
         entry_index_ff <= '0;
         frame_comp_ff  <= '0;
         scan_comp_ff   <= '0;
         comp_index_ff  <= '0;
         after_ff_ff    <= 1'b0;
         scan_tables_ff <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         byte_cnt_ff    <= byte_cnt_in;
         high_byte_ff   <= high_byte_in;
         byte_offset_ff <= byte_offset_in;
         field_start_ff <= field_start_in;
         seg_end_ff     <= seg_end_in;
         precision_ff   <= precision_in;
         entry_index_ff <= entry_index_in;
         frame_comp_ff  <= frame_comp_in;
         scan_comp_ff   <= scan_comp_in;
         comp_index_ff  <= comp_index_in;
         after_ff_ff    <= after_ff_in;
         scan_tables_ff <= scan_tables_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_skip_has_end: assert property (@(posedge clock) disable iff (reset)
      (step && result.hit && result.field_kind == jmsp_pkg::KIND_SKIPPED)
      |-> (cur_phase == jmsp_pkg::PH_SKIP))
      else $error("skipped-data word outside a skip segment");
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      (step && result.hit && result.field_kind == jmsp_pkg::KIND_DQT_ENT)
      |=> (phase_ff == jmsp_pkg::PH_DQT_ENT || phase_ff == jmsp_pkg::PH_DQT_PT ||
           phase_ff == jmsp_pkg::PH_TMARK))
      else $error("DQT entry left parser in a wrong phase");
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jmsp_pkg::PH_HALT && !word.new_stream) |-> !result.hit)
      else $error("result while halted");
`endif

endmodule

`default_nettype wire

// ===== rtl/jpeg_marker_segment_parser.sv =====
// Top level of the JPEG marker segment parser: input register, parse core, result register.
// Takes one file byte per word on req_if and reports each completed header field on
// rsp_if as kind, value, start offset and index. It accepts one byte per cycle, and takes
// fewer only while rsp_if stalls with both registers full. A byte waits in the input
// register until the parse step advances, which loads any field it completes into the
// result register, from which it is offered on rsp_if. Raise new_stream with the first
// byte of each file.
`default_nettype none

module jpeg_marker_segment_parser (
   input  wire logic   clock,
   input  wire logic   reset,
   jmsp_req_if.sink    req_if,
   jmsp_rsp_if.source  rsp_if
);

   logic                       in_valid_ff, in_valid_in;
   jmsp_pkg::jmsp_word_type    in_word_ff;
   logic                       out_valid_ff, out_valid_in;
   jmsp_pkg::jmsp_result_type  out_res_ff;
   jmsp_pkg::jmsp_result_type  step_result;
   logic                       advance;
   logic                       req_take;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_result.hit;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   jmsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (in_word_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.data_byte  <= req_if.data_byte;
         in_word_ff.new_stream <= req_if.new_stream;
      end
      if (advance) begin
         out_res_ff <= step_result;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.field_kind   = out_res_ff.field_kind;
   assign rsp_if.field_value  = out_res_ff.field_value;
   assign rsp_if.field_offset = out_res_ff.field_offset;
   assign rsp_if.field_index  = out_res_ff.field_index;

`ifndef NO_ASSERTIONS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_if.ready)
      else $error("input register empty but not ready");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("stalled input word lost");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.field_kind <= jmsp_pkg::KIND_SOS_AHAL))
      else $error("field kind out of range");
   a_index_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.field_index != 8'd0) |->
      (rsp_if.field_kind == jmsp_pkg::KIND_DQT_ENT ||
       rsp_if.field_kind == jmsp_pkg::KIND_SOF_C ||
       rsp_if.field_kind == jmsp_pkg::KIND_SOF_HV ||
       rsp_if.field_kind == jmsp_pkg::KIND_SOF_TQ ||
       rsp_if.field_kind == jmsp_pkg::KIND_SOS_CS ||
       rsp_if.field_kind == jmsp_pkg::KIND_SOS_TDTA))
      else $error("index on a field kind that has none");
`endif

endmodule

`default_nettype wire
